// ===== rtl/irpd_pkg.sv =====
// Shared types, constants and the key code ROM for the IR pulse-distance key decoder.
// No dependencies; used by every module of the block.
package irpd_pkg;

  localparam int unsigned TimeW = 16;
  localparam int unsigned KeyW = 5;
  localparam int unsigned CodeW = 32;
  localparam int unsigned SecretW = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FrameMaxW = 64;
  localparam int unsigned PassMax = 8;
  localparam int unsigned SecretExtW = KeyW * PassMax;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 40;

  localparam int unsigned FrameBitsDef = 32;
  localparam int unsigned KeyEntriesDef = 21;
  localparam int unsigned PassLenDef = 4;

  localparam logic [TimeW-1:0] OneMinRst = 16'd52000;
  localparam logic [TimeW-1:0] OneMaxRst = 16'd56000;
  localparam logic [TimeW-1:0] ZeroMinRst = 16'd25000;
  localparam logic [TimeW-1:0] ZeroMaxRst = 16'd30000;
  localparam logic [SecretW-1:0] SecretRst = 20'd103525;

  typedef enum logic [CfgIdxW-1:0] {
    RegOneMin  = 3'd0,
    RegOneMax  = 3'd1,
    RegZeroMin = 3'd2,
    RegZeroMax = 3'd3,
    RegSecret  = 3'd4
  } cfg_reg_e;

  localparam int unsigned RomSize = 21;
  localparam logic [CodeW-1:0] KeyRom [RomSize] = '{
    32'h00FF6897, 32'h00FF30CF, 32'h00FF18E7, 32'h00FF7A85, 32'h00FF10EF,
    32'h00FF38C7, 32'h00FF5AA5, 32'h00FF5AA5, 32'h00FF5AA5, 32'h00FF5AA5,
    32'h00FFA25D, 32'h00FF629D, 32'h00FFE21D, 32'h00FF22DD, 32'h00FF02FD,
    32'h00FFC23D, 32'h00FFE01F, 32'h00FFA857, 32'h00FF906F, 32'h007FCC33,
    32'h00FFB04F
  };

  typedef struct packed {
    logic [TimeW-1:0] one_min;
    logic [TimeW-1:0] one_max;
    logic [TimeW-1:0] zero_min;
    logic [TimeW-1:0] zero_max;
  } window_cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [FrameMaxW-1:0] frame;
  } frame_evt_t;

  typedef struct packed {
    logic            pass_ok;
    logic            pass_done;
    logic [KeyW-1:0] key_index;
    logic [CodeW-1:0] frame_code;
  } result_t;

endpackage

// ===== rtl/irpd_bit_rx.sv =====
// Edge distance measurement, bit window classification and frame shift register.
// Depends on irpd_pkg for widths and the window configuration struct.
module irpd_bit_rx #(
  parameter int unsigned FRAME_BITS = irpd_pkg::FrameBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [irpd_pkg::TimeW-1:0]    edge_time_i,
  input  irpd_pkg::window_cfg_t         win_i,
  output irpd_pkg::frame_evt_t          frame_o
);
  import irpd_pkg::*;

  localparam int unsigned CntW = $clog2(FRAME_BITS);

  logic [TimeW-1:0]      last_edge_q;
  logic [CntW-1:0]       bit_count_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic [TimeW-1:0]      delta;
  logic                  is_one;
  logic                  is_zero;
  logic                  hit;
  logic                  last_bit;
  logic [FRAME_BITS-1:0] frame_next;

  assign delta = edge_time_i - last_edge_q;
  assign is_one = (delta > win_i.one_min) && (delta < win_i.one_max);
  assign is_zero = (delta > win_i.zero_min) && (delta < win_i.zero_max);
  assign hit = is_one || is_zero;
  assign frame_next = {frame_q[FRAME_BITS-2:0], is_one};
  assign last_bit = (bit_count_q == CntW'(FRAME_BITS - 1));

  assign frame_o.valid = hit && last_bit;
  assign frame_o.frame = FrameMaxW'(frame_next);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q <= '0;
      bit_count_q <= '0;
      frame_q     <= '0;
    end else if (step_i) begin
      last_edge_q <= edge_time_i;
      if (hit) begin
        if (last_bit) begin
          bit_count_q <= '0;
          frame_q     <= '0;
        end else begin
          bit_count_q <= bit_count_q + 1'b1;
          frame_q     <= frame_next;
        end
      end
    end
  end

endmodule

// ===== rtl/irpd_key_match.sv =====
// Key ROM lookup and passcode collection and check for completed frames.
// Depends on irpd_pkg for the ROM, widths and the frame and result structs.
module irpd_key_match #(
  parameter int unsigned KEY_ENTRIES = irpd_pkg::KeyEntriesDef,
  parameter int unsigned PASS_LEN    = irpd_pkg::PassLenDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  irpd_pkg::frame_evt_t          frame_i,
  input  logic [irpd_pkg::SecretW-1:0]  secret_i,
  output irpd_pkg::result_t             result_o
);
  import irpd_pkg::*;

  localparam int unsigned KCntW = $clog2(PASS_LEN + 1);
  localparam logic [KeyW-1:0] NoMatch = KeyW'(KEY_ENTRIES);

  logic [KCntW-1:0]      key_count_q;
  logic [KeyW-1:0]       entered_q [PASS_LEN];
  logic [KeyW-1:0]       key;
  logic                  found;
  logic                  last_key;
  logic [PASS_LEN-1:0]   slot_eq;
  logic [SecretExtW-1:0] secret_ext;
  logic                  store;

  always_comb begin
    key   = NoMatch;
    found = 1'b0;
    for (int i = RomSize - 1; i >= 0; i--) begin
      if ((i < KEY_ENTRIES) && (frame_i.frame == FrameMaxW'(KeyRom[i]))) begin
        key   = KeyW'(i);
        found = 1'b1;
      end
    end
  end

  assign secret_ext = SecretExtW'(secret_i);
  assign last_key = (key_count_q == KCntW'(PASS_LEN - 1));

  for (genvar k = 0; k < PASS_LEN; k++) begin : g_slot
    if (k == PASS_LEN - 1) begin : g_new
      assign slot_eq[k] = (key == secret_ext[KeyW*(PASS_LEN-1-k) +: KeyW]);
    end else begin : g_old
      assign slot_eq[k] = (entered_q[k] == secret_ext[KeyW*(PASS_LEN-1-k) +: KeyW]);
    end
  end

  assign store = step_i && frame_i.valid && found;

  assign result_o.frame_code = frame_i.frame[CodeW-1:0];
  assign result_o.key_index  = key;
  assign result_o.pass_done  = found && last_key;
  assign result_o.pass_ok    = found && last_key && (&slot_eq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (store) begin
      if (last_key) begin
        key_count_q <= '0;
      end else begin
        key_count_q <= key_count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < PASS_LEN; k++) begin
      if (store && (key_count_q == KCntW'(k))) begin
        entered_q[k] <= key;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_q < KCntW'(PASS_LEN))
    else $error("Passcode key count left its range.");
`endif

endmodule

// ===== rtl/ir_pulse_distance_key_decoder.sv =====
// Top level of the IR pulse-distance key decoder: configuration registers,
// input and result registers, and the stream handshakes.
// Depends on irpd_pkg, irpd_bit_rx and irpd_key_match.
//
// Usage: each slave transaction carries the free-running timer value captured
// at one falling edge of the IR line. The block measures the distance to the
// previous edge, turns it into a 1, a 0 or nothing, and after a full frame
// emits one master transaction with the frame code, the matched key index and
// the passcode verdict. Edges that do not complete a frame produce nothing.
// The edge that completes a frame passes through the input register, then
// the result register, which presents the result on the master side.
// Throughput: one edge per cycle; the window compare, frame shift, parallel
// ROM compare and passcode check all sit in the one stage between registers.
// When the master side stalls, the result register holds its transaction and
// the input register holds one more edge; tready drops only then.
// The configuration port takes a write in any cycle; writes are meant to be
// done while the block is idle and act on the next edge.
// Reset clears the edge time, bit and key counters, the pending transactions
// and restores the default windows and passcode.
module ir_pulse_distance_key_decoder #(
  parameter int unsigned FRAME_BITS  = irpd_pkg::FrameBitsDef,
  parameter int unsigned KEY_ENTRIES = irpd_pkg::KeyEntriesDef,
  parameter int unsigned PASS_LEN    = irpd_pkg::PassLenDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // edge_time[15:0]
  input  logic [irpd_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // frame_code[31:0], key_index[36:32], pass_done[37], pass_ok[38], zero[39]
  output logic [irpd_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [irpd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [irpd_pkg::SecretW-1:0]   cfg_data_i
);
  import irpd_pkg::*;

  window_cfg_t      win_q;
  logic [SecretW-1:0] secret_q;
  logic             in_valid_q;
  logic [TimeW-1:0] in_time_q;
  logic             out_valid_q;
  result_t          out_q;
  logic             advance;
  frame_evt_t       frame_evt;
  result_t          result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.one_min  <= OneMinRst;
      win_q.one_max  <= OneMaxRst;
      win_q.zero_min <= ZeroMinRst;
      win_q.zero_max <= ZeroMaxRst;
      secret_q       <= SecretRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegOneMin:  win_q.one_min  <= cfg_data_i[TimeW-1:0];
        RegOneMax:  win_q.one_max  <= cfg_data_i[TimeW-1:0];
        RegZeroMin: win_q.zero_min <= cfg_data_i[TimeW-1:0];
        RegZeroMax: win_q.zero_max <= cfg_data_i[TimeW-1:0];
        RegSecret:  secret_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_time_q <= s_axis_tdata[TimeW-1:0];
    end
  end

  irpd_bit_rx #(
    .FRAME_BITS (FRAME_BITS)
  ) u_bit_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .edge_time_i (in_time_q),
    .win_i       (win_q),
    .frame_o     (frame_evt)
  );

  irpd_key_match #(
    .KEY_ENTRIES (KEY_ENTRIES),
    .PASS_LEN    (PASS_LEN)
  ) u_key_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .frame_i  (frame_evt),
    .secret_i (secret_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= advance && frame_evt.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && frame_evt.valid) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.pass_ok, out_q.pass_done, out_q.key_index,
                          out_q.frame_code};

`ifndef SYNTHESIS
  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pass_ok |-> out_q.pass_done)
    else $error("Passcode verdict given without a completed passcode.");

  a_nomatch_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.key_index == KeyW'(KEY_ENTRIES)) |-> !out_q.pass_done)
    else $error("Unmatched frame completed a passcode.");

  a_frame_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && frame_evt.valid |=> out_valid_q)
    else $error("Completed frame did not reach the result register.");

  a_stall_keeps_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_time_q))
    else $error("Pending edge lost while the result side stalled.");
`endif

endmodule

// ===== tb/sv/ir_pulse_distance_key_decoder_tb.sv =====
// Self-checking testbench for the IR pulse-distance key decoder: drives edge
// timestamps as whole frames and noise, predicts each frame's key and passcode verdict.
// Depends on irpd_pkg and ir_pulse_distance_key_decoder.
module ir_pulse_distance_key_decoder_tb;
  import irpd_pkg::*;

  localparam int unsigned ClkPeriod = 8;
  localparam int unsigned TimeoutCycles = 400_000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned SqueezeCycles = 300;
  localparam int unsigned MaxReports = 10;

  class key_scoreboard;
    logic [TimeW-1:0] one_lo, one_hi, zero_lo, zero_hi;
    logic [SecretW-1:0] passcode;
    logic [TimeW-1:0] prev_edge;
    logic [CodeW-1:0] shifter;
    logic [KeyW-1:0] keys [PassLenDef];
    int unsigned bits_in, bits_total, keys_in;
    result_t expected_frames [$];
    int unsigned edges_noted, frames_done, keys_found, checks_done, checks_ok;
    int unsigned mismatches, strays, reports;

    function new();
      one_lo = OneMinRst;
      one_hi = OneMaxRst;
      zero_lo = ZeroMinRst;
      zero_hi = ZeroMaxRst;
      passcode = SecretRst;
      prev_edge = '0;
      shifter = '0;
      bits_in = 0;
      bits_total = 0;
      keys_in = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [SecretW-1:0] value);
      case (idx)
        RegOneMin: one_lo = value[TimeW-1:0];
        RegOneMax: one_hi = value[TimeW-1:0];
        RegZeroMin: zero_lo = value[TimeW-1:0];
        RegZeroMax: zero_hi = value[TimeW-1:0];
        RegSecret: passcode = value;
        default: ;
      endcase
    endfunction

    function int unsigned rom_lookup(logic [CodeW-1:0] frame);
      for (int i = 0; i < RomSize && i < KeyEntriesDef; i++) begin
        if (KeyRom[i] == frame) return i;
      end
      return KeyEntriesDef;
    endfunction

    function bit passcode_ok();
      for (int k = 0; k < PassLenDef; k++) begin
        if (keys[k] != passcode[KeyW*(PassLenDef-1-k) +: KeyW]) return 0;
      end
      return 1;
    endfunction

    function void note_edge(logic [TimeW-1:0] stamp);
      logic [TimeW-1:0] span;
      logic shift_in;
      logic [CodeW-1:0] frame;
      int unsigned idx;
      result_t res;
      span = stamp - prev_edge;
      prev_edge = stamp;
      edges_noted++;
      // The one window takes precedence where the two windows overlap.
      if (span > one_lo && span < one_hi) shift_in = 1'b1;
      else if (span > zero_lo && span < zero_hi) shift_in = 1'b0;
      else return;
      shifter = {shifter[CodeW-2:0], shift_in};
      bits_in++;
      bits_total++;
      if (bits_in < FrameBitsDef) return;
      frame = shifter;
      shifter = '0;
      bits_in = 0;
      frames_done++;
      idx = rom_lookup(frame);
      res.frame_code = frame;
      res.key_index = idx[KeyW-1:0];
      res.pass_done = 1'b0;
      res.pass_ok = 1'b0;
      if (idx < KeyEntriesDef) begin
        keys_found++;
        keys[keys_in] = idx[KeyW-1:0];
        keys_in++;
        if (keys_in == PassLenDef) begin
          res.pass_done = 1'b1;
          res.pass_ok = passcode_ok();
          keys_in = 0;
          checks_done++;
          if (res.pass_ok) checks_ok++;
        end
      end
      expected_frames.push_back(res);
    endfunction

    function void check_result(logic [OutDataW-1:0] tdata);
      result_t got, want;
      got = tdata[$bits(result_t)-1:0];
      if (expected_frames.size() == 0) begin
        strays++;
        if (reports < MaxReports) begin
          $display("Unexpected result: frame %h key %0d done %0b ok %0b",
                   got.frame_code, got.key_index, got.pass_done, got.pass_ok);
        end
        reports++;
        return;
      end
      want = expected_frames.pop_front();
      if (got.frame_code !== want.frame_code || got.key_index !== want.key_index ||
          got.pass_done !== want.pass_done || got.pass_ok !== want.pass_ok) begin
        mismatches++;
        if (reports < MaxReports) begin
          $display("Result mismatch: expected frame %h key %0d done %0b ok %0b",
                   want.frame_code, want.key_index, want.pass_done, want.pass_ok);
          $display("                 actual   frame %h key %0d done %0b ok %0b",
                   got.frame_code, got.key_index, got.pass_done, got.pass_ok);
        end
        reports++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // edge_time[15:0]
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // frame_code[31:0], key_index[36:32], pass_done[37], pass_ok[38], zero[39]
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [SecretW-1:0] cfg_data_i = '0;

  key_scoreboard sb = new();
  bit tx_steady;
  int unsigned hold_req;

  ir_pulse_distance_key_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Returns a distance that lands in the window for the wanted bit, falling
  // back to the other window when that one is empty or shadowed.
  function automatic logic [TimeW-1:0] pick_span(logic want_one);
    logic [TimeW-1:0] span;
    if (want_one && sb.one_hi > sb.one_lo + 1) begin
      return TimeW'($urandom_range(sb.one_lo + 1, sb.one_hi - 1));
    end
    if (sb.zero_hi > sb.zero_lo + 1) begin
      for (int i = 0; i < 8; i++) begin
        span = TimeW'($urandom_range(sb.zero_lo + 1, sb.zero_hi - 1));
        if (!(span > sb.one_lo && span < sb.one_hi)) return span;
      end
    end
    if (sb.one_hi > sb.one_lo + 1) begin
      return TimeW'($urandom_range(sb.one_lo + 1, sb.one_hi - 1));
    end
    return '0;
  endfunction

  task automatic send_edge(logic [TimeW-1:0] stamp);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= stamp;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_edge(stamp);
    gap = tx_steady ? 0 : pick_pause();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_span(logic [TimeW-1:0] span);
    logic [TimeW-1:0] stamp;
    stamp = sb.prev_edge + span;
    send_edge(stamp);
  endtask

  task automatic send_noise();
    logic [TimeW-1:0] span;
    int unsigned r;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) span = '0;
      else if (r < 15) span = '1;
      else span = TimeW'($urandom);
      if (!(span > sb.one_lo && span < sb.one_hi) &&
          !(span > sb.zero_lo && span < sb.zero_hi)) break;
      span = '0;
    end
    send_span(span);
  endtask

  task automatic send_bit(logic want_one);
    if ($urandom_range(0, 99) < 3) send_noise();
    send_span(pick_span(want_one));
  endtask

  task automatic send_frame(logic [CodeW-1:0] code);
    for (int i = CodeW - 1; i >= 0; i--) send_bit(code[i]);
  endtask

  task automatic send_key(int unsigned idx);
    send_frame(KeyRom[idx]);
  endtask

  task automatic align_bits();
    while (sb.bits_in != 0) send_bit($urandom_range(0, 1));
  endtask

  task automatic send_key_group(bit correct);
    int unsigned tries, digit, r;
    logic [CodeW-1:0] code;
    tries = 0;
    align_bits();
    while (sb.keys_in != 0 && tries < PassLenDef) begin
      send_key($urandom_range(0, RomSize - 1));
      tries++;
    end
    for (int k = 0; k < PassLenDef; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_frame(CodeW'($urandom));
      end else if (r < 16) begin
        code = KeyRom[$urandom_range(0, RomSize - 1)] ^ (32'h1 << $urandom_range(0, CodeW - 1));
        send_frame(code);
      end
      digit = 32'(sb.passcode[KeyW*(PassLenDef-1-k) +: KeyW]);
      if (correct && digit < RomSize) send_key(digit);
      else send_key($urandom_range(0, RomSize - 1));
    end
  endtask

  task automatic wait_drained();
    while (sb.expected_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [CfgIdxW-1:0] idx, logic [SecretW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic apply_settings(logic [TimeW-1:0] one_lo, logic [TimeW-1:0] one_hi,
                                logic [TimeW-1:0] zero_lo, logic [TimeW-1:0] zero_hi,
                                logic [SecretW-1:0] code);
    put_reg(RegOneMin, SecretW'(one_lo));
    put_reg(RegOneMax, SecretW'(one_hi));
    put_reg(RegZeroMin, SecretW'(zero_lo));
    put_reg(RegZeroMax, SecretW'(zero_hi));
    put_reg(RegSecret, code);
    // Writes to indexes past the register list must leave everything alone.
    for (int i = int'(RegSecret) + 1; i < (1 << CfgIdxW); i++) begin
      put_reg(CfgIdxW'(i), SecretW'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int unsigned bit_budget, bit squeeze);
    int unsigned start;
    bit first;
    start = sb.bits_total;
    first = squeeze;
    while (sb.bits_total - start < bit_budget) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      if (first) begin
        hold_req = SqueezeCycles;
        tx_steady = 1'b1;
        first = 1'b0;
      end
      send_key_group($urandom_range(0, 1));
    end
    align_bits();
    s_axis_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    int unsigned cycle_n, hold_left, low_left;
    bit rx_steady;
    cycle_n = 0;
    hold_left = 0;
    low_left = 0;
    rx_steady = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      cycle_n++;
      if (cycle_n % 256 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (low_left != 0) begin
        m_axis_tready <= 1'b0;
        low_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_steady) low_left = pick_pause();
      end
    end
  end

  initial begin
    logic [TimeW-1:0] probes [9];
    int unsigned errors;
    probes = '{OneMinRst, OneMinRst + 16'd1, OneMaxRst - 16'd1, OneMaxRst,
               ZeroMinRst, ZeroMinRst + 16'd1, ZeroMaxRst - 16'd1, ZeroMaxRst, 16'd0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Equal stamps, the largest distance, a wrap past zero, then window edges.
    send_edge('0);
    send_edge('1);
    send_span(OneMinRst + 16'd2000);
    foreach (probes[i]) send_span(probes[i]);

    run_phase(300, 1'b1);
    apply_settings('0, '1, '0, '1, '1);
    run_phase(60, 1'b0);
    apply_settings(16'd1000, 16'd2000, 16'd100, 16'd600,
                   {5'($urandom_range(0, 20)), 5'($urandom_range(0, 20)),
                    5'($urandom_range(0, 20)), 5'($urandom_range(0, 20))});
    run_phase(150, 1'b0);
    apply_settings(16'd30000, 16'd40000, 16'd35000, 16'd60000, '0);
    run_phase(250, 1'b1);
    apply_settings('1, '0, '0, '1, SecretW'($urandom));
    run_phase(60, 1'b0);
    apply_settings(OneMinRst, OneMaxRst, ZeroMinRst, ZeroMaxRst, SecretRst);
    run_phase(150, 1'b1);

    errors = sb.mismatches + sb.strays + sb.expected_frames.size();
    $display("Covered %0d edge transactions (%0d inside a bit window), %0d frames, %0d known keys.",
             sb.edges_noted, sb.bits_total, sb.frames_done, sb.keys_found);
    $display("Passcode verdicts: %0d, %0d accepted; %0d mismatches, %0d unexpected results.",
             sb.checks_done, sb.checks_ok, sb.mismatches, sb.strays);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Timeout with %0d results outstanding.", sb.expected_frames.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
